/* rtl/cau_pkg.sv */
// complex arithmetic unit package: widths, codes, sideband struct, saturation
// used by cau_div and complex_arithmetic_unit_top; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

   localparam int DATA_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int NUM_W      = SUM_W + FRAC_W;
   localparam int DEN_W      = PROD_W;
   localparam int Q_W        = DATA_W + 1;
   localparam int INIT_W     = NUM_W - Q_W;
   localparam int REM_W      = (INIT_W > DEN_W + 1) ? INIT_W : DEN_W + 1;
   localparam int DIV_STAGES = Q_W + 1;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } cau_op_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_OVF = 2'd1,
      ST_DZ  = 2'd2
   } cau_status_type;

   typedef struct packed {
      cau_op_type          op;
      logic                dz;
      logic [1:0]          neg;
      logic [DATA_W-1:0]   re;
      logic [DATA_W-1:0]   im;
      cau_status_type      status;
   } cau_side_type;

   typedef struct packed {
      logic [DATA_W-1:0] val;
      logic              ovf;
   } cau_sat_type;

   function automatic cau_sat_type cau_sat(input logic signed [NUM_W-1:0] v);
      cau_sat_type             r;
      logic signed [NUM_W-1:0] hi;
      logic signed [NUM_W-1:0] lo;
      hi = NUM_W'($signed({1'b0, {(DATA_W-1){1'b1}}}));
      lo = NUM_W'($signed({1'b1, {(DATA_W-1){1'b0}}}));
      if (v > hi) begin
         r.val = hi[DATA_W-1:0];
         r.ovf = 1'b1;
      end else if (v < lo) begin
         r.val = lo[DATA_W-1:0];
         r.ovf = 1'b1;
      end else begin
         r.val = v[DATA_W-1:0];
         r.ovf = 1'b0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/complex_arithmetic_unit_top.sv */
// Complex add, subtract, multiply and divide on signed Q16.16 parts. Every operation
// runs through one pipeline of 37 stages: products, sums, the 34-stage divider fed by
// combinational scaling (one quotient bit per stage after its first) and the output
// register, so a beat is taken every cycle while no stall holds the output. A stall on the
// result side freezes the whole pipeline and is passed back to req_stall.
// depends on cau_pkg and cau_div
`timescale 1ns / 1ps
`default_nettype none

module complex_arithmetic_unit_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [1:0]                          req_operation,
   input  wire logic signed [cau_pkg::DATA_W-1:0]   req_a_re,
   input  wire logic signed [cau_pkg::DATA_W-1:0]   req_a_im,
   input  wire logic signed [cau_pkg::DATA_W-1:0]   req_b_re,
   input  wire logic signed [cau_pkg::DATA_W-1:0]   req_b_im,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [cau_pkg::DATA_W-1:0]        rsp_res_re,
   output logic signed [cau_pkg::DATA_W-1:0]        rsp_res_im,
   output logic [1:0]                               rsp_status
);
   import cau_pkg::*;

   logic en;

   // stage 1: products
   logic                        s1_valid_ff;
   cau_op_type                  s1_op_ff;
   logic signed [PROD_W-1:0]    p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_dr_ff, p_di_ff;
   logic signed [PROD_W-1:0]    p_rr_in, p_ii_in, p_ri_in, p_ir_in, p_dr_in, p_di_in;
   logic signed [DATA_W:0]      as_re_ff, as_im_ff, as_re_in, as_im_in;

   // stage 2: sums
   logic                        s2_valid_ff;
   cau_op_type                  s2_op_ff;
   logic signed [SUM_W-1:0]     re_sum_ff, im_sum_ff, re_sum_in, im_sum_in;
   logic [DEN_W-1:0]            den_ff, den_in;

   // scaling into divider
   cau_side_type                side_in;
   logic [1:0][NUM_W-1:0]       mag_in;
   logic signed [NUM_W-1:0]     num_re, num_im;
   cau_sat_type                 fast_re, fast_im;

   logic                        dv_valid;
   cau_side_type                dv_side;
   logic [1:0][Q_W-1:0]         dv_q;
   logic [1:0]                  dv_big;

   logic                        rsp_valid_ff;
   logic [DATA_W-1:0]           res_re_ff, res_im_ff, res_re_in, res_im_in;
   cau_status_type              status_ff, status_in;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_comb begin
      p_rr_in = req_a_re * req_b_re;
      p_ii_in = req_a_im * req_b_im;
      p_ri_in = req_a_re * req_b_im;
      p_ir_in = req_a_im * req_b_re;
      p_dr_in = req_b_re * req_b_re;
      p_di_in = req_b_im * req_b_im;
      if (cau_op_type'(req_operation) == OP_SUB) begin
         as_re_in = (DATA_W+1)'(req_a_re) - (DATA_W+1)'(req_b_re);
         as_im_in = (DATA_W+1)'(req_a_im) - (DATA_W+1)'(req_b_im);
      end else begin
         as_re_in = (DATA_W+1)'(req_a_re) + (DATA_W+1)'(req_b_re);
         as_im_in = (DATA_W+1)'(req_a_im) + (DATA_W+1)'(req_b_im);
      end
   end

   always_comb begin
      den_in = DEN_W'($unsigned(p_dr_ff)) + DEN_W'($unsigned(p_di_ff));
      case (s1_op_ff)
         OP_MUL: begin
            re_sum_in = SUM_W'(p_rr_ff) - SUM_W'(p_ii_ff);
            im_sum_in = SUM_W'(p_ri_ff) + SUM_W'(p_ir_ff);
         end
         OP_DIV: begin
            re_sum_in = SUM_W'(p_rr_ff) + SUM_W'(p_ii_ff);
            im_sum_in = SUM_W'(p_ir_ff) - SUM_W'(p_ri_ff);
         end
         default: begin
            re_sum_in = SUM_W'(as_re_ff);
            im_sum_in = SUM_W'(as_im_ff);
         end
      endcase
   end

   always_comb begin
      if (s2_op_ff == OP_MUL) begin
         fast_re = cau_sat(NUM_W'(re_sum_ff >>> FRAC_W));
         fast_im = cau_sat(NUM_W'(im_sum_ff >>> FRAC_W));
      end else begin
         fast_re = cau_sat(NUM_W'(re_sum_ff));
         fast_im = cau_sat(NUM_W'(im_sum_ff));
      end
      num_re = NUM_W'(re_sum_ff) <<< FRAC_W;
      num_im = NUM_W'(im_sum_ff) <<< FRAC_W;
      side_in.op     = s2_op_ff;
      side_in.dz     = den_ff == '0;
      side_in.neg    = {num_im[NUM_W-1], num_re[NUM_W-1]};
      side_in.re     = fast_re.val;
      side_in.im     = fast_im.val;
      side_in.status = (fast_re.ovf || fast_im.ovf) ? ST_OVF : ST_OK;
      mag_in[0] = num_re[NUM_W-1] ? NUM_W'(-num_re) : NUM_W'(num_re);
      mag_in[1] = num_im[NUM_W-1] ? NUM_W'(-num_im) : NUM_W'(num_im);
   end

   cau_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s2_valid_ff),
      .in_side   (side_in),
      .in_mag    (mag_in),
      .in_den    (den_ff),
      .out_valid (dv_valid),
      .out_side  (dv_side),
      .out_q     (dv_q),
      .out_big   (dv_big)
   );

   always_comb begin
      logic signed [Q_W+1:0]   v;
      logic signed [NUM_W-1:0] w;
      cau_sat_type             sr;
      cau_sat_type             si;
      v = dv_side.neg[0] ? -$signed({2'b00, dv_q[0]}) : $signed({2'b00, dv_q[0]});
      w = dv_big[0] ? (dv_side.neg[0] ? {1'b1, {(NUM_W-1){1'b0}}}
                                      : {1'b0, {(NUM_W-1){1'b1}}}) : NUM_W'(v);
      sr = cau_sat(w);
      v = dv_side.neg[1] ? -$signed({2'b00, dv_q[1]}) : $signed({2'b00, dv_q[1]});
      w = dv_big[1] ? (dv_side.neg[1] ? {1'b1, {(NUM_W-1){1'b0}}}
                                      : {1'b0, {(NUM_W-1){1'b1}}}) : NUM_W'(v);
      si = cau_sat(w);
      if (dv_side.op != OP_DIV) begin
         res_re_in = dv_side.re;
         res_im_in = dv_side.im;
         status_in = dv_side.status;
      end else if (dv_side.dz) begin
         res_re_in = '0;
         res_im_in = '0;
         status_in = ST_DZ;
      end else begin
         res_re_in = sr.val;
         res_im_in = si.val;
         status_in = (sr.ovf || si.ovf) ? ST_OVF : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_op_ff  <= cau_op_type'(req_operation);
         p_rr_ff   <= p_rr_in;
         p_ii_ff   <= p_ii_in;
         p_ri_ff   <= p_ri_in;
         p_ir_ff   <= p_ir_in;
         p_dr_ff   <= p_dr_in;
         p_di_ff   <= p_di_in;
         as_re_ff  <= as_re_in;
         as_im_ff  <= as_im_in;
         s2_op_ff  <= s1_op_ff;
         re_sum_ff <= re_sum_in;
         im_sum_ff <= im_sum_in;
         den_ff    <= den_in;
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_res_re = res_re_ff;
   assign rsp_res_im = res_im_ff;
   assign rsp_status = status_ff;

   a_dz_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_DZ |-> res_re_ff == '0 && res_im_ff == '0)
      else $error("divide by zero beat with nonzero result");

   a_ovf_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_OVF |->
         res_re_ff == {1'b0, {(DATA_W-1){1'b1}}} || res_re_ff == {1'b1, {(DATA_W-1){1'b0}}} ||
         res_im_ff == {1'b0, {(DATA_W-1){1'b1}}} || res_im_ff == {1'b1, {(DATA_W-1){1'b0}}})
      else $error("overflow status without a saturated part");

   a_div_hold : assert property (@(posedge clock) disable iff (reset)
      !en && !$past(reset) |=> $stable(dv_valid) && $stable(dv_q) && $stable(dv_big))
      else $error("divider moved while output stalled");

   a_stall_src : assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $past(rsp_valid_ff) && $stable(res_re_ff) && $stable(status_ff))
      else $error("input stalled without a held output beat");

endmodule

`default_nettype wire

/* rtl/cau_div.sv */
// restoring divide pipeline, one quotient bit per stage after the first, two lanes (re, im)
// depends on cau_pkg; sideband struct and valid bits travel with the data
`timescale 1ns / 1ps
`default_nettype none

module cau_div (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  en,
   input  wire logic                                  in_valid,
   input  wire cau_pkg::cau_side_type                 in_side,
   input  wire logic [1:0][cau_pkg::NUM_W-1:0]        in_mag,
   input  wire logic [cau_pkg::DEN_W-1:0]             in_den,
   output logic                                       out_valid,
   output cau_pkg::cau_side_type                      out_side,
   output logic [1:0][cau_pkg::Q_W-1:0]               out_q,
   output logic [1:0]                                 out_big
);
   import cau_pkg::*;

   logic                        valid_ff [DIV_STAGES];
   logic                        valid_in [DIV_STAGES];
   cau_side_type                side_ff  [DIV_STAGES];
   cau_side_type                side_in  [DIV_STAGES];
   logic [DEN_W-1:0]            den_ff   [DIV_STAGES];
   logic [DEN_W-1:0]            den_in   [DIV_STAGES];
   logic [1:0][REM_W-1:0]       rem_ff   [DIV_STAGES];
   logic [1:0][REM_W-1:0]       rem_in   [DIV_STAGES];
   logic [1:0][Q_W-1:0]         low_ff   [DIV_STAGES];
   logic [1:0][Q_W-1:0]         low_in   [DIV_STAGES];
   logic [1:0][Q_W-1:0]         q_ff     [DIV_STAGES];
   logic [1:0][Q_W-1:0]         q_in     [DIV_STAGES];
   logic [1:0]                  big_ff   [DIV_STAGES];
   logic [1:0]                  big_in   [DIV_STAGES];

   always_comb begin
      logic [REM_W-1:0] t;
      logic             qbit;
      valid_in[0] = in_valid;
      side_in[0]  = in_side;
      den_in[0]   = in_den;
      for (int l = 0; l < 2; l++) begin
         rem_in[0][l] = REM_W'(in_mag[l][NUM_W-1:Q_W]);
         big_in[0][l] = REM_W'(in_mag[l][NUM_W-1:Q_W]) >= REM_W'(in_den);
         low_in[0][l] = in_mag[l][Q_W-1:0];
         q_in[0][l]   = '0;
      end
      for (int s = 1; s < DIV_STAGES; s++) begin
         valid_in[s] = valid_ff[s-1];
         side_in[s]  = side_ff[s-1];
         den_in[s]   = den_ff[s-1];
         big_in[s]   = big_ff[s-1];
         for (int l = 0; l < 2; l++) begin
            t = {rem_ff[s-1][l][REM_W-2:0], low_ff[s-1][l][Q_W-1]};
            qbit = t >= REM_W'(den_ff[s-1]);
            rem_in[s][l] = qbit ? t - REM_W'(den_ff[s-1]) : t;
            q_in[s][l]   = {q_ff[s-1][l][Q_W-2:0], qbit};
            low_in[s][l] = {low_ff[s-1][l][Q_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STAGES; s++) valid_ff[s] <= 1'b0;
      end else if (en) begin
         for (int s = 0; s < DIV_STAGES; s++) valid_ff[s] <= valid_in[s];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            side_ff[s] <= side_in[s];
            den_ff[s]  <= den_in[s];
            rem_ff[s]  <= rem_in[s];
            low_ff[s]  <= low_in[s];
            q_ff[s]    <= q_in[s];
            big_ff[s]  <= big_in[s];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];
   assign out_q     = q_ff[DIV_STAGES-1];
   assign out_big   = big_ff[DIV_STAGES-1];

endmodule

`default_nettype wire
